// ===== hdl/fpa_pkg.sv =====
// Shared operation and status codes of the fixed-point ALU.
`default_nettype none
package fpa_pkg;

  typedef enum logic [3:0] {
    ACT_ADD = 4'd0,
    ACT_SUB = 4'd1,
    ACT_MUL = 4'd2,
    ACT_DIV = 4'd3,
    ACT_GT  = 4'd4,
    ACT_LT  = 4'd5,
    ACT_GE  = 4'd6,
    ACT_LE  = 4'd7,
    ACT_EQ  = 4'd8,
    ACT_NE  = 4'd9,
    ACT_MIN = 4'd10,
    ACT_MAX = 4'd11,
    ACT_INC = 4'd12,
    ACT_DEC = 4'd13
  } action_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_DIVZ = 2'd2
  } status_e;

endpackage
`default_nettype wire

// ===== hdl/fpa_front.sv =====
// Entry stage: magnitudes, signs and the add, subtract, increment, decrement, compare, min and max results.
`default_nettype none
module fpa_front
  import fpa_pkg::*;
#(
  parameter int W  = 32,
  parameter int AW = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [3:0]          action_i,
  input  logic signed [W-1:0] a_i,
  input  logic signed [W-1:0] b_i,
  output logic [W+W+AW+(W+1)+W+4+1+1+1+2-1:0] stage_o
);

  typedef struct packed {
    logic         valid;
    action_e      action;
    logic         neg;
    logic [W-1:0] ma;
    logic [W-1:0] mb;
    logic [AW-1:0] acc;
    logic [W:0]   rem;
    logic [W-1:0] sval;
    logic         scmp;
    status_e      sstat;
  } stage_t;

  stage_t            stage_d, stage_q;
  action_e           act;
  logic signed [W:0] ax, bx, sum;
  logic              lt, gt, arith, sat_hi, sat_lo;

  assign act = action_e'(action_i);
  assign ax  = {a_i[W-1], a_i};
  assign bx  = {b_i[W-1], b_i};
  assign lt  = a_i < b_i;
  assign gt  = b_i < a_i;

  always_comb begin
    sum   = '0;
    arith = 1'b0;
    unique case (act)
      ACT_ADD: begin sum = ax + bx; arith = 1'b1; end
      ACT_SUB: begin sum = ax - bx; arith = 1'b1; end
      ACT_INC: begin sum = ax + (W+1)'(1); arith = 1'b1; end
      ACT_DEC: begin sum = ax - (W+1)'(1); arith = 1'b1; end
      default: begin sum = '0; arith = 1'b0; end
    endcase
  end

  assign sat_hi = !sum[W] && sum[W-1];
  assign sat_lo = sum[W] && !sum[W-1];

  always_comb begin
    stage_d        = '0;
    stage_d.valid  = valid_i;
    stage_d.action = act;
    stage_d.neg    = a_i[W-1] ^ b_i[W-1];
    stage_d.ma     = a_i[W-1] ? W'(-a_i) : W'(a_i);
    stage_d.mb     = b_i[W-1] ? W'(-b_i) : W'(b_i);
    stage_d.sstat  = ST_OK;
    if (arith) begin
      if (sat_hi) begin
        stage_d.sval  = {1'b0, {(W-1){1'b1}}};
        stage_d.sstat = ST_OVF;
      end else if (sat_lo) begin
        stage_d.sval  = {1'b1, {(W-1){1'b0}}};
        stage_d.sstat = ST_OVF;
      end else begin
        stage_d.sval = sum[W-1:0];
      end
    end
    unique case (act)
      ACT_GT:  stage_d.scmp = gt;
      ACT_LT:  stage_d.scmp = lt;
      ACT_GE:  stage_d.scmp = !lt;
      ACT_LE:  stage_d.scmp = !gt;
      ACT_EQ:  stage_d.scmp = a_i == b_i;
      ACT_NE:  stage_d.scmp = a_i != b_i;
      ACT_MIN: stage_d.sval = lt ? a_i : b_i;
      ACT_MAX: stage_d.sval = gt ? a_i : b_i;
      default: stage_d.scmp = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule
`default_nettype wire

// ===== hdl/fpa_cell.sv =====
// One cell of the chain: a shift-add multiply step or a restoring divide step.
`default_nettype none
module fpa_cell
  import fpa_pkg::*;
#(
  parameter int W  = 32,
  parameter int F  = 8,
  parameter int AW = 64,
  parameter int K  = 0
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic [W+W+AW+(W+1)+W+4+1+1+1+2-1:0] stage_i,
  output logic [W+W+AW+(W+1)+W+4+1+1+1+2-1:0] stage_o
);

  typedef struct packed {
    logic         valid;
    action_e      action;
    logic         neg;
    logic [W-1:0] ma;
    logic [W-1:0] mb;
    logic [AW-1:0] acc;
    logic [W:0]   rem;
    logic [W-1:0] sval;
    logic         scmp;
    status_e      sstat;
  } stage_t;

  localparam int N   = W + F;
  localparam int IDX = N - 1 - K;

  stage_t        cur, stage_d, stage_q;
  logic [AW-1:0] mul_acc;
  logic          bit_in, ge;
  logic [W:0]    rem2, diff;

  assign cur = stage_i;

  if (K < W) begin : g_mul
    always_comb begin
      mul_acc = cur.acc;
      if (cur.mb[K]) begin
        mul_acc[K +: W+1] = cur.acc[K +: W+1] + {1'b0, cur.ma};
      end
    end
  end else begin : g_nomul
    assign mul_acc = cur.acc;
  end

  if (IDX >= F) begin : g_bit
    assign bit_in = cur.ma[IDX-F];
  end else begin : g_zero
    assign bit_in = 1'b0;
  end

  assign rem2 = {cur.rem[W-1:0], bit_in};
  assign ge   = rem2 >= {1'b0, cur.mb};
  assign diff = rem2 - {1'b0, cur.mb};

  always_comb begin
    stage_d = cur;
    if (cur.action == ACT_MUL) begin
      stage_d.acc = mul_acc;
    end else if (cur.action == ACT_DIV) begin
      stage_d.rem = ge ? diff : rem2;
      stage_d.acc = {cur.acc[AW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule
`default_nettype wire

// ===== hdl/fpa_back.sv =====
// Exit stage: rounding, saturation, divide-by-zero handling and the output register.
`default_nettype none
module fpa_back
  import fpa_pkg::*;
#(
  parameter int W  = 32,
  parameter int F  = 8,
  parameter int AW = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic [W+W+AW+(W+1)+W+4+1+1+1+2-1:0] stage_i,
  output logic          valid_o,
  output logic [W-1:0]  value_o,
  output logic          cmp_o,
  output logic [1:0]    status_o
);

  typedef struct packed {
    logic         valid;
    action_e      action;
    logic         neg;
    logic [W-1:0] ma;
    logic [W-1:0] mb;
    logic [AW-1:0] acc;
    logic [W:0]   rem;
    logic [W-1:0] sval;
    logic         scmp;
    status_e      sstat;
  } stage_t;

  localparam int MW = AW + 1;

  stage_t        cur;
  logic [MW-1:0] pm, q, mag, lim, magc;
  logic          rnd, over;
  logic [W-1:0]  v, value_d, value_q;
  logic          cmp_d, cmp_q, valid_q;
  status_e       status_d, status_q;

  assign cur  = stage_i;
  assign pm   = ({1'b0, cur.acc} + (MW'(1) << (F-1))) >> F;
  assign rnd  = {cur.rem[W-1:0], 1'b0} >= {1'b0, cur.mb};
  assign q    = {1'b0, cur.acc} + MW'(rnd);
  assign mag  = (cur.action == ACT_MUL) ? pm : q;
  assign lim  = {{(MW-W){1'b0}}, 1'b1, {(W-1){1'b0}}} - MW'(!cur.neg);
  assign over = mag > lim;
  assign magc = over ? lim : mag;
  assign v    = magc[W-1:0];

  always_comb begin
    value_d  = cur.sval;
    cmp_d    = cur.scmp;
    status_d = cur.sstat;
    if (cur.action == ACT_DIV && cur.mb == '0) begin
      status_d = ST_DIVZ;
      if (cur.ma == '0) begin
        value_d = '0;
      end else begin
        value_d = cur.neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end
    end else if (cur.action == ACT_MUL || cur.action == ACT_DIV) begin
      value_d  = cur.neg ? W'(-v) : v;
      status_d = over ? ST_OVF : ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      value_q  <= '0;
      cmp_q    <= 1'b0;
      status_q <= ST_OK;
    end else if (en_i) begin
      valid_q  <= cur.valid;
      value_q  <= value_d;
      cmp_q    <= cmp_d;
      status_q <= status_d;
    end
  end

  assign valid_o  = valid_q;
  assign value_o  = value_q;
  assign cmp_o    = cmp_q;
  assign status_o = status_q;

endmodule
`default_nettype wire

// ===== hdl/fixed_point_alu.sv =====
// Top level of the signed fixed-point ALU.
// Every item passes an entry stage, a chain of VALUE_WIDTH + FRACTION_BITS cells and an
// output register, and one item is taken every cycle while the output is not stalled.
// The default parameters give Q24.8. Multiply uses one shift-add step in each of the first
// VALUE_WIDTH cells, divide one restoring quotient bit per cell; the cell count is
// set by the divide, which needs one cell for each bit of the shifted dividend. The whole
// chain stalls while a result waits at the output.
`default_nettype none
module fixed_point_alu
  import fpa_pkg::*;
#(
  parameter int FRACTION_BITS = 8,
  parameter int VALUE_WIDTH   = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [3:0]                    action_i,
  input  logic signed [VALUE_WIDTH-1:0] operand_a_i,
  input  logic signed [VALUE_WIDTH-1:0] operand_b_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [VALUE_WIDTH-1:0] result_value_o,
  output logic                          compare_true_o,
  output logic [1:0]                    status_o
);

  localparam int W  = VALUE_WIDTH;
  localparam int F  = FRACTION_BITS;
  localparam int NC = W + F;
  localparam int AW = (2*W > W+F) ? 2*W : W+F;
  localparam int SW = W+W+AW+(W+1)+W+4+1+1+1+2;

  logic          en;
  logic [SW-1:0] chain [NC+1];

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  fpa_front #(.W(W), .AW(AW)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .action_i(action_i),
    .a_i     (operand_a_i),
    .b_i     (operand_b_i),
    .stage_o (chain[0])
  );

  for (genvar k = 0; k < NC; k++) begin : g_cell
    fpa_cell #(.W(W), .F(F), .AW(AW), .K(k)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .stage_i(chain[k]),
      .stage_o(chain[k+1])
    );
  end

  fpa_back #(.W(W), .F(F), .AW(AW)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .stage_i (chain[NC]),
    .valid_o (out_valid_o),
    .value_o (result_value_o),
    .cmp_o   (compare_true_o),
    .status_o(status_o)
  );

  a_cmp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && compare_true_o |-> result_value_o == '0 && status_o == ST_OK)
    else $error("comparison result carries a value or status");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 2'd3)
    else $error("undefined status code");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_value_o)
      && $stable(compare_true_o) && $stable(status_o))
    else $error("stalled result changed");

endmodule
`default_nettype wire
